>>> sv/scr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg: shared definitions of the sector cache tag controller
// request and status codes, pending operation codes, parameter defaults and
// the command bundle from the controller to the datapath
// ----------------------------------------------------------------------------
package scr_pkg;

  // parameter defaults
  localparam int SLOTS_DEF     = 8;
  localparam int AGE_BITS_DEF  = 16;
  localparam int ADDR_BITS_DEF = 32;

  // request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_IO     = 2'd1;
  localparam logic [1:0] REQ_MARK   = 2'd2;
  localparam logic [1:0] REQ_FLUSH  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_WB_CMD  = 3'd1;
  localparam logic [2:0] ST_FILL    = 3'd2;
  localparam logic [2:0] ST_FILLED  = 3'd3;
  localparam logic [2:0] ST_WR_FAIL = 3'd4;
  localparam logic [2:0] ST_RD_FAIL = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;
  localparam logic [2:0] ST_IGNORED = 3'd7;

  // pending storage operation
  localparam logic [1:0] OP_NONE     = 2'd0;
  localparam logic [1:0] OP_MISS_WB  = 2'd1;
  localparam logic [1:0] OP_FILL     = 2'd2;
  localparam logic [1:0] OP_FLUSH_WB = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } scr_cmd_t;

endpackage

>>> sv/sector_cache_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_replacement: tag controller of a write-back sector cache
// Requests come in on the in_ channel as one beat each: lookup, storage io
// done, mark slot modified, or flush all. Each request yields exactly one
// result beat on the out_ channel: status, slot and command address.
// A request is captured and then evaluated in the execute step (tag compare,
// age check and priority pick over all slots in parallel); out_valid rises
// once the result is registered. A new request is taken only after the last
// one has executed, limited by the capture and execute steps of the sequencer.
// The result sits in an output register; a new request is accepted while it
// waits, and its evaluation holds until the receiver takes the old result.
// A flush runs as a sequence of write-back commands, one per io done beat.
// Synchronous active-low reset empties the cache, clears age state and
// drops any pending storage operation; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sector_cache_replacement #(
  parameter int SLOTS     = scr_pkg::SLOTS_DEF,
  parameter int AGE_BITS  = scr_pkg::AGE_BITS_DEF,
  parameter int ADDR_BITS = scr_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_sector_addr,
  input  logic [2:0]  in_slot_sel,
  input  logic        in_io_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [31:0] out_cmd_addr
);

  scr_pkg::scr_cmd_t cmd;

  // sequencer
  scr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // tag store and datapath
  scr_dp #(
    .SLOTS     (SLOTS),
    .AGE_BITS  (AGE_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_sector_addr (in_sector_addr),
    .in_slot_sel    (in_slot_sel),
    .in_io_ok       (in_io_ok),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_cmd_addr   (out_cmd_addr)
  );

`ifndef SYNTH
  // one request in flight: no new beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // an execute cycle always leaves a result waiting
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid)
    else $error("execute cycle produced no result");

  // execute never overwrites a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> (!out_valid || out_ready))
    else $error("result register overwritten while stalled");
`endif

endmodule

>>> sv/scr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_ctrl: request sequencer
// takes one request beat, runs its execute step once the result register is
// free, and tracks the result register's valid flag
// ----------------------------------------------------------------------------
module scr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output scr_pkg::scr_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // handshake and commands
  assign in_ready    = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.execute) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/scr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_dp: tag store and request datapath
// holds the per-slot tags, valid, dirty and age stamps, the pending storage
// operation, and computes one result per request in its execute cycle
// ----------------------------------------------------------------------------
module scr_dp #(
  parameter int SLOTS     = scr_pkg::SLOTS_DEF,
  parameter int AGE_BITS  = scr_pkg::AGE_BITS_DEF,
  parameter int ADDR_BITS = scr_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scr_pkg::scr_cmd_t cmd,
  input  logic [1:0]        in_req_type,
  input  logic [31:0]       in_sector_addr,
  input  logic [2:0]        in_slot_sel,
  input  logic              in_io_ok,
  output logic [2:0]        out_status,
  output logic [2:0]        out_slot,
  output logic [31:0]       out_cmd_addr
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;
  localparam int DW = AGE_BITS + 7;
  localparam int XW = SW + 3;

  // captured request
  logic [1:0]           req_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [2:0]           sel_r;
  logic                 ok_r;
  logic [ADDR_BITS+31:0] addr_wide;

  assign addr_wide = {{ADDR_BITS{1'b0}}, in_sector_addr};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      addr_r <= addr_wide[ADDR_BITS-1:0];
      sel_r  <= in_slot_sel;
      ok_r   <= in_io_ok;
    end
  end

  // tag store and controller state
  logic [ADDR_BITS-1:0] tag_r [SLOTS];
  logic [AGE_BITS-1:0]  stamp_r [SLOTS];
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [SLOTS-1:0]     dirty_r, dirty_nxt;
  logic [AGE_BITS-1:0]  counter_r, counter_nxt;
  logic [1:0]           pop_r, pop_nxt;
  logic [SW-1:0]        pslot_r, pslot_nxt;
  logic [ADDR_BITS-1:0] paddr_r, paddr_nxt;
  logic                 tag_we, stamp_we, stamp_clr;

  // per-slot lanes
  logic [AGE_BITS-1:0] age_diff [SLOTS];
  logic [SLOTS-1:0]    hit_vec, cand_vec, vd_vec, passed_vec;
  logic [CW-1:0]       scan_start;
  logic                hit_any, found_any;
  logic [SW-1:0]       hit_idx, victim_idx, found_idx, rd_slot;
  logic                flush_cont;
  logic [ADDR_BITS-1:0] tag_rd;

  assign scan_start = (req_r == scr_pkg::REQ_FLUSH) ? '0 : ({1'b0, pslot_r} + CW'(1));
  assign flush_cont = (req_r == scr_pkg::REQ_IO) && (pop_r == scr_pkg::OP_FLUSH_WB) && ok_r;

  // tag compare, age test and flush candidates
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      age_diff[i] = counter_r - stamp_r[i];
      hit_vec[i]  = valid_r[i] && (tag_r[i] == addr_r);
      cand_vec[i] = !valid_r[i] || ({7'b0, age_diff[i]} >= DW'(SLOTS)) || (i == SLOTS - 1);
      vd_vec[i]   = valid_r[i] && dirty_r[i] && (CW'(i) >= scan_start);
    end
  end

  // priority picks, lowest slot wins
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    found_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i])  hit_idx    = SW'(i);
      if (cand_vec[i]) victim_idx = SW'(i);
      if (vd_vec[i])   found_idx  = SW'(i);
    end
    hit_any   = |hit_vec;
    found_any = |vd_vec;
  end

  // clean slots the flush scan passes over
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      passed_vec[j] = (CW'(j) >= scan_start) && (SW'(j) < found_idx);
    end
  end

  // single tag read port
  always_comb begin
    if (req_r == scr_pkg::REQ_LOOKUP) rd_slot = victim_idx;
    else if (req_r == scr_pkg::REQ_FLUSH || flush_cont) rd_slot = found_idx;
    else rd_slot = pslot_r;
  end
  assign tag_rd = tag_r[rd_slot];

  // mark modified slot select
  logic [XW-1:0] sel_x;
  logic          sel_ok;
  assign sel_x  = {{SW{1'b0}}, sel_r};
  assign sel_ok = (sel_x < XW'(SLOTS));

  // request execution
  logic [2:0]           res_status;
  logic [SW-1:0]        res_slot;
  logic [ADDR_BITS-1:0] res_addr;
  logic                 do_scan;

  always_comb begin
    valid_nxt   = valid_r;
    dirty_nxt   = dirty_r;
    counter_nxt = counter_r;
    pop_nxt     = pop_r;
    pslot_nxt   = pslot_r;
    paddr_nxt   = paddr_r;
    tag_we      = 1'b0;
    stamp_we    = 1'b0;
    stamp_clr   = 1'b0;
    do_scan     = 1'b0;
    res_status  = scr_pkg::ST_IGNORED;
    res_slot    = '0;
    res_addr    = '0;
    case (req_r)
      scr_pkg::REQ_LOOKUP: begin
        if (pop_r != scr_pkg::OP_NONE) begin
          res_status = scr_pkg::ST_IGNORED;
        end else if (hit_any) begin
          res_status = scr_pkg::ST_HIT;
          res_slot   = hit_idx;
          res_addr   = addr_r;
        end else begin
          pslot_nxt = victim_idx;
          paddr_nxt = addr_r;
          res_slot  = victim_idx;
          if (valid_r[victim_idx] && dirty_r[victim_idx]) begin
            pop_nxt    = scr_pkg::OP_MISS_WB;
            res_status = scr_pkg::ST_WB_CMD;
            res_addr   = tag_rd;
          end else begin
            valid_nxt[victim_idx] = 1'b0;
            pop_nxt    = scr_pkg::OP_FILL;
            res_status = scr_pkg::ST_FILL;
            res_addr   = addr_r;
          end
        end
      end
      scr_pkg::REQ_IO: begin
        res_slot = pslot_r;
        case (pop_r)
          scr_pkg::OP_MISS_WB: begin
            if (ok_r) begin
              dirty_nxt[pslot_r] = 1'b0;
              valid_nxt[pslot_r] = 1'b0;
              pop_nxt    = scr_pkg::OP_FILL;
              res_status = scr_pkg::ST_FILL;
              res_addr   = paddr_r;
            end else begin
              pop_nxt    = scr_pkg::OP_NONE;
              res_status = scr_pkg::ST_WR_FAIL;
              res_addr   = tag_rd;
            end
          end
          scr_pkg::OP_FILL: begin
            pop_nxt  = scr_pkg::OP_NONE;
            res_addr = paddr_r;
            if (ok_r) begin
              counter_nxt        = counter_r + AGE_BITS'(1);
              tag_we             = 1'b1;
              stamp_we           = 1'b1;
              valid_nxt[pslot_r] = 1'b1;
              dirty_nxt[pslot_r] = 1'b0;
              res_status         = scr_pkg::ST_FILLED;
            end else begin
              res_status = scr_pkg::ST_RD_FAIL;
            end
          end
          scr_pkg::OP_FLUSH_WB: begin
            if (ok_r) begin
              dirty_nxt[pslot_r] = 1'b0;
              valid_nxt[pslot_r] = 1'b0;
              do_scan            = 1'b1;
            end else begin
              pop_nxt    = scr_pkg::OP_NONE;
              res_status = scr_pkg::ST_WR_FAIL;
              res_addr   = tag_rd;
            end
          end
          default: begin
            res_status = scr_pkg::ST_IGNORED;
            res_slot   = '0;
          end
        endcase
      end
      scr_pkg::REQ_MARK: begin
        if (sel_ok) begin
          dirty_nxt[sel_x[SW-1:0]] = 1'b1;
          res_status = scr_pkg::ST_DONE;
          res_slot   = sel_x[SW-1:0];
        end
      end
      default: begin
        if (pop_r == scr_pkg::OP_NONE) do_scan = 1'b1;
      end
    endcase

    // flush scan step: next dirty slot or completion
    if (do_scan) begin
      if (found_any) begin
        valid_nxt  = valid_nxt & ~passed_vec;
        pop_nxt    = scr_pkg::OP_FLUSH_WB;
        pslot_nxt  = found_idx;
        res_status = scr_pkg::ST_WB_CMD;
        res_slot   = found_idx;
        res_addr   = tag_rd;
      end else begin
        valid_nxt   = '0;
        dirty_nxt   = '0;
        stamp_clr   = 1'b1;
        counter_nxt = '0;
        pop_nxt     = scr_pkg::OP_NONE;
        pslot_nxt   = '0;
        res_status  = scr_pkg::ST_DONE;
        res_slot    = '0;
        res_addr    = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      dirty_r   <= '0;
      counter_r <= '0;
      pop_r     <= scr_pkg::OP_NONE;
      pslot_r   <= '0;
      for (int i = 0; i < SLOTS; i++) stamp_r[i] <= '0;
    end else if (cmd.execute) begin
      valid_r   <= valid_nxt;
      dirty_r   <= dirty_nxt;
      counter_r <= counter_nxt;
      pop_r     <= pop_nxt;
      pslot_r   <= pslot_nxt;
      if (stamp_clr) begin
        for (int i = 0; i < SLOTS; i++) stamp_r[i] <= '0;
      end else if (stamp_we) begin
        stamp_r[pslot_r] <= counter_nxt;
      end
    end
  end

  // tags and pending address, no reset
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      paddr_r <= paddr_nxt;
      if (tag_we) tag_r[pslot_r] <= paddr_r;
    end
  end

  // result register
  logic [XW-1:0]         slot_x;
  logic [ADDR_BITS+31:0] res_wide;
  assign slot_x   = {3'b0, res_slot};
  assign res_wide = {32'b0, res_addr};

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status   <= res_status;
      out_slot     <= slot_x[2:0];
      out_cmd_addr <= res_wide[31:0];
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sector cache tag controller
// Drives lookup, io done, mark modified and flush requests through the in_
// channel and checks every out_ beat against a shadow copy of the tag store
// that is updated as each request beat is accepted. Directed cases come
// first, then random well-formed miss and flush sequences with noise, with
// random idle bursts on both channels and a final stretch with none.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NSLOT      = scr_pkg::SLOTS_DEF;
  localparam int QUIET_MAX  = 2000;
  localparam int TAIL_CYC   = 8;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [31:0] cmd_addr;
  } cache_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = scr_pkg::REQ_LOOKUP;
  logic [31:0] in_sector_addr = '0;
  logic [2:0]  in_slot_sel = '0;
  logic        in_io_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_slot;
  logic [31:0] out_cmd_addr;

  // shadow tag store and controller state
  logic [31:0] sh_tag [NSLOT];
  logic        sh_valid [NSLOT];
  logic        sh_dirty [NSLOT];
  logic [15:0] sh_stamp [NSLOT];
  logic [15:0] sh_age;
  logic [1:0]  sh_op;
  logic [2:0]  sh_slot;
  logic [31:0] sh_addr;

  cache_reply_t expected_replies [$];
  int          status_tally [8];
  int          errors = 0;
  int          req_count = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;
  logic [31:0] addr_pool [16];

  sector_cache_replacement dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_sector_addr (in_sector_addr),
    .in_slot_sel    (in_slot_sel),
    .in_io_ok       (in_io_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_cmd_addr   (out_cmd_addr)
  );

  // clock
  always #10 clk = ~clk;

  // flush scan: write back the next valid dirty slot, else empty the cache
  function automatic cache_reply_t flush_walk(input int start);
    cache_reply_t r;
    for (int j = start; j < NSLOT; j++) begin
      if (sh_valid[j] && sh_dirty[j]) begin
        sh_op   = scr_pkg::OP_FLUSH_WB;
        sh_slot = 3'(j);
        r = '{scr_pkg::ST_WB_CMD, 3'(j), sh_tag[j]};
        return r;
      end
      sh_valid[j] = 1'b0;
    end
    for (int j = 0; j < NSLOT; j++) begin
      sh_valid[j] = 1'b0;
      sh_dirty[j] = 1'b0;
      sh_stamp[j] = '0;
    end
    sh_age  = '0;
    sh_op   = scr_pkg::OP_NONE;
    sh_slot = '0;
    r = '{scr_pkg::ST_DONE, 3'd0, 32'd0};
    return r;
  endfunction

  // tag compare, then victim pick on a miss
  function automatic cache_reply_t lookup_sector(input logic [31:0] addr);
    cache_reply_t r;
    logic [15:0]  diff;
    int           v;
    v = NSLOT - 1;
    for (int i = 0; i < NSLOT; i++) begin
      if (sh_valid[i] && sh_tag[i] == addr) begin
        r = '{scr_pkg::ST_HIT, 3'(i), addr};
        return r;
      end
    end
    for (int i = 0; i < NSLOT; i++) begin
      diff = sh_age - sh_stamp[i];
      if (i == NSLOT - 1 || !sh_valid[i] || diff >= 16'(NSLOT)) begin
        v = i;
        break;
      end
    end
    sh_slot = 3'(v);
    sh_addr = addr;
    if (sh_valid[v] && sh_dirty[v]) begin
      sh_op = scr_pkg::OP_MISS_WB;
      r = '{scr_pkg::ST_WB_CMD, 3'(v), sh_tag[v]};
    end else begin
      sh_valid[v] = 1'b0;
      sh_op = scr_pkg::OP_FILL;
      r = '{scr_pkg::ST_FILL, 3'(v), addr};
    end
    return r;
  endfunction

  // storage outcome of the pending command
  function automatic cache_reply_t finish_io(input logic ok);
    cache_reply_t r;
    int           s;
    s = sh_slot;
    case (sh_op)
      scr_pkg::OP_MISS_WB: begin
        if (ok) begin
          sh_dirty[s] = 1'b0;
          sh_valid[s] = 1'b0;
          sh_op = scr_pkg::OP_FILL;
          r = '{scr_pkg::ST_FILL, 3'(s), sh_addr};
        end else begin
          sh_op = scr_pkg::OP_NONE;
          r = '{scr_pkg::ST_WR_FAIL, 3'(s), sh_tag[s]};
        end
      end
      scr_pkg::OP_FILL: begin
        sh_op = scr_pkg::OP_NONE;
        if (ok) begin
          sh_age = sh_age + 16'd1;
          sh_tag[s] = sh_addr;
          sh_valid[s] = 1'b1;
          sh_dirty[s] = 1'b0;
          sh_stamp[s] = sh_age;
          r = '{scr_pkg::ST_FILLED, 3'(s), sh_addr};
        end else begin
          r = '{scr_pkg::ST_RD_FAIL, 3'(s), sh_addr};
        end
      end
      scr_pkg::OP_FLUSH_WB: begin
        if (ok) begin
          sh_dirty[s] = 1'b0;
          sh_valid[s] = 1'b0;
          r = flush_walk(s + 1);
        end else begin
          sh_op = scr_pkg::OP_NONE;
          r = '{scr_pkg::ST_WR_FAIL, 3'(s), sh_tag[s]};
        end
      end
      default: r = '{scr_pkg::ST_IGNORED, 3'd0, 32'd0};
    endcase
    return r;
  endfunction

  // expected reply of one accepted request beat
  function automatic cache_reply_t predict_cache_reply(input logic [1:0] rt,
      input logic [31:0] addr, input logic [2:0] sel, input logic ok);
    cache_reply_t r;
    case (rt)
      scr_pkg::REQ_LOOKUP: begin
        if (sh_op != scr_pkg::OP_NONE) r = '{scr_pkg::ST_IGNORED, 3'd0, 32'd0};
        else                           r = lookup_sector(addr);
      end
      scr_pkg::REQ_IO: r = finish_io(ok);
      scr_pkg::REQ_MARK: begin
        sh_dirty[sel] = 1'b1;
        r = '{scr_pkg::ST_DONE, sel, 32'd0};
      end
      default: begin
        if (sh_op != scr_pkg::OP_NONE) r = '{scr_pkg::ST_IGNORED, 3'd0, 32'd0};
        else                           r = flush_walk(0);
      end
    endcase
    return r;
  endfunction

  // send one request beat, with an optional idle burst ahead of it
  task automatic send_req(input logic [1:0] rt, input logic [31:0] addr,
      input logic [2:0] sel, input logic ok);
    cache_reply_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rt;
    in_sector_addr <= addr;
    in_slot_sel    <= sel;
    in_io_ok       <= ok;
    do @(posedge clk); while (!in_ready);
    r = predict_cache_reply(rt, addr, sel, ok);
    expected_replies.push_back(r);
    status_tally[r.status]++;
    req_count++;
  endtask

  // wait until every expected reply has come back, then a short tail
  task automatic drain_replies();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  // io done with nothing pending
  task automatic test_stray_io();
    send_req(scr_pkg::REQ_IO, $urandom, 3'd5, 1'b1);
    send_req(scr_pkg::REQ_IO, $urandom, 3'd2, 1'b0);
  endtask

  // fill on a miss, then a hit, at address zero; then a failed fill at all ones
  task automatic test_fill_and_hit();
    send_req(scr_pkg::REQ_LOOKUP, 32'h0000_0000, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_IO, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_req(scr_pkg::REQ_LOOKUP, 32'h0000_0000, 3'd7, 1'b1);
    send_req(scr_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 3'd1, 1'b1);
    send_req(scr_pkg::REQ_IO, 32'h0, 3'd0, 1'b0);
  endtask

  // requests while busy are ignored, then the fill completes
  task automatic test_busy();
    send_req(scr_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 3'd3, 1'b0);
    send_req(scr_pkg::REQ_LOOKUP, 32'h1234_5678, 3'd4, 1'b1);
    send_req(scr_pkg::REQ_FLUSH, 32'h0, 3'd6, 1'b0);
    send_req(scr_pkg::REQ_IO, 32'h0, 3'd0, 1'b1);
  endtask

  // mark modified on a valid and on an invalid slot
  task automatic test_mark();
    send_req(scr_pkg::REQ_MARK, 32'h0, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_MARK, 32'hFFFF_FFFF, 3'd7, 1'b1);
  endtask

  // flush with write-back success, then a failed flush and a retry
  task automatic test_flush();
    send_req(scr_pkg::REQ_FLUSH, 32'h0, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_IO, 32'h0, 3'd0, 1'b1);
    send_req(scr_pkg::REQ_LOOKUP, 32'h5A5A_0F0F, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_IO, 32'h0, 3'd0, 1'b1);
    send_req(scr_pkg::REQ_MARK, 32'h0, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_FLUSH, 32'h0, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_IO, 32'h0, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_FLUSH, 32'h0, 3'd0, 1'b0);
    send_req(scr_pkg::REQ_IO, 32'h0, 3'd0, 1'b1);
  endtask

  // random traffic: mostly lookups answered by io done, plus noise
  task automatic run_traffic(input int count, input int pool_size);
    int          pick;
    logic [31:0] addr;
    for (int k = 0; k < 16; k++) addr_pool[k] = $urandom;
    for (int n = 0; n < count; n++) begin
      addr = addr_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 7) == 0) addr = $urandom;
      if (sh_op != scr_pkg::OP_NONE) begin
        pick = $urandom_range(0, 9);
        if (pick < 8)
          send_req(scr_pkg::REQ_IO, $urandom, 3'($urandom),
                   1'($urandom_range(0, 4) != 0));
        else if (pick == 8)
          send_req($urandom_range(0, 1) ? scr_pkg::REQ_LOOKUP : scr_pkg::REQ_FLUSH,
                   addr, 3'($urandom), 1'($urandom));
        else
          send_req(scr_pkg::REQ_MARK, $urandom, 3'($urandom), 1'($urandom));
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 13)
          send_req(scr_pkg::REQ_LOOKUP, addr, 3'($urandom), 1'($urandom));
        else if (pick < 17)
          send_req(scr_pkg::REQ_MARK, $urandom, 3'($urandom), 1'($urandom));
        else if (pick == 17)
          send_req(scr_pkg::REQ_FLUSH, $urandom, 3'($urandom), 1'($urandom));
        else if (pick == 18)
          send_req(scr_pkg::REQ_IO, $urandom, 3'($urandom), 1'($urandom));
        else
          send_req(scr_pkg::REQ_LOOKUP, $urandom, 3'($urandom), 1'($urandom));
      end
    end
  endtask

  // hit-heavy traffic over a few sectors
  task automatic test_hit_mix();
    run_traffic(600, 6);
  endtask

  // more sectors than slots, so victims age out and get written back
  task automatic test_eviction();
    run_traffic(800, 16);
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_steady_stream();
    drain_replies();
    idle_on = 1'b0;
    run_traffic(400, 12);
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each result beat with the oldest expected reply
  always @(posedge clk) begin
    cache_reply_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat status %0d slot %0d addr %h",
                 $time, out_status, out_slot, out_cmd_addr);
      end else begin
        e = expected_replies.pop_front();
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
        end
        if (out_slot !== e.slot) begin
          errors++;
          $display("%0t: slot expected %0d actual %0d", $time, e.slot, out_slot);
        end
        if (out_cmd_addr !== e.cmd_addr) begin
          errors++;
          $display("%0t: cmd_addr expected %h actual %h", $time, e.cmd_addr, out_cmd_addr);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("%0t: no beat for %0d cycles", $time, QUIET_MAX);
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_tag[i]   = '0;
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
      sh_stamp[i] = '0;
    end
    sh_age  = '0;
    sh_op   = scr_pkg::OP_NONE;
    sh_slot = '0;
    sh_addr = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stray_io();
    test_fill_and_hit();
    test_busy();
    test_mark();
    test_flush();
    test_hit_mix();
    test_eviction();
    test_steady_stream();
    drain_replies();
    $display("run covered %0d requests: %0d hits, %0d write-back cmds, %0d fill cmds",
             req_count, status_tally[scr_pkg::ST_HIT], status_tally[scr_pkg::ST_WB_CMD],
             status_tally[scr_pkg::ST_FILL]);
    $display("  %0d filled, %0d write fails, %0d read fails, %0d done, %0d ignored",
             status_tally[scr_pkg::ST_FILLED], status_tally[scr_pkg::ST_WR_FAIL],
             status_tally[scr_pkg::ST_RD_FAIL], status_tally[scr_pkg::ST_DONE],
             status_tally[scr_pkg::ST_IGNORED]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
sv/scr_pkg.sv
sv/scr_ctrl.sv
sv/scr_dp.sv
sv/sector_cache_replacement.sv
test/testbench.sv
